// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the stereo biquad RTL
// Each macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SBQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SBQ_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ----- rtl/sbq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbq_pkg
// Shared constants, register codes and types of the stereo biquad block.
// ---------------------------------------------------------------------------
package sbq_pkg;

    localparam int COEF_W  = 32;
    localparam int NCOEF   = 5;
    localparam int SHIFT_W = 4;
    localparam int NPORT   = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 28;
    localparam int DEF_CHANNELS       = 2;

    // Coefficient slots
    localparam int C_B0 = 0;
    localparam int C_B1 = 1;
    localparam int C_B2 = 2;
    localparam int C_A1 = 3;
    localparam int C_A2 = 4;

    // Register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_B0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_A1    = 3'd3;
    localparam logic [IDX_W-1:0] REG_A2    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT = 3'd5;

    localparam logic [COEF_W-1:0]  TGT_B0_RESET = 32'h1000_0000;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 4'd9;

    typedef logic [NCOEF-1:0][COEF_W-1:0] coef_set_t;

    typedef struct packed {
        logic load;
        logic start;
        logic last;
    } ramp_ctrl_t;

endpackage

// ----- rtl/stereo_biquad_coef_ramp_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// stereo_biquad_coef_ramp_core
// Stereo Direct Form I biquad with coefficient ramping, APB register port.
// ---------------------------------------------------------------------------
// One request per clock cycle sustained while the output is not stalled; each
// request is registered in the first stage, then moves into the output register
// once that register is free. The first stage applies the coefficient ramp, the
// second runs both channel lanes (five multiplies each), whose output history
// is updated on each advance, and loads the output register. Program the targets and
// block_shift only while no request is in flight.
module stereo_biquad_coef_ramp_core #(
    parameter int SAMPLE_BITS    = sbq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = sbq_pkg::DEF_COEF_FRAC_BITS,
    parameter int CHANNELS       = sbq_pkg::DEF_CHANNELS,
    localparam int IN_TDATA_W    = ((4 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbq_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbq_pkg::DATA_W-1:0]  pwdata,
    output logic [sbq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_TDATA_W-1:0]       s_tdata,  // in_left, in_right, mix_left, mix_right
    input  logic                        s_tuser,  // block_start
    input  logic                        s_tlast,  // block_end

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata   // out_left, out_right
);
    import sbq_pkg::*;

    // Register file
    coef_set_t          tgt_reg, tgt_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [IDX_W-1:0]   idx;
    logic               wr;

    assign idx    = paddr[IDX_W+1:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        tgt_next   = tgt_reg;
        shift_next = shift_reg;
        if (wr)
        begin
            unique case (idx)
                REG_B0:    tgt_next[C_B0] = pwdata;
                REG_B1:    tgt_next[C_B1] = pwdata;
                REG_B2:    tgt_next[C_B2] = pwdata;
                REG_A1:    tgt_next[C_A1] = pwdata;
                REG_A2:    tgt_next[C_A2] = pwdata;
                REG_SHIFT: shift_next     = pwdata[SHIFT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_B0:    prdata = tgt_reg[C_B0];
            REG_B1:    prdata = tgt_reg[C_B1];
            REG_B2:    prdata = tgt_reg[C_B2];
            REG_A1:    prdata = tgt_reg[C_A1];
            REG_A2:    prdata = tgt_reg[C_A2];
            REG_SHIFT: prdata = DATA_W'(shift_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg       <= '0;
            tgt_reg[C_B0] <= TGT_B0_RESET;
            shift_reg     <= SHIFT_RESET;
        end
        else
        begin
            tgt_reg   <= tgt_next;
            shift_reg <= shift_next;
        end
    end

    // Pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic accept, adv, out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign adv      = s1_valid_reg && out_free;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1: coefficient ramp and sample capture
    ramp_ctrl_t ctrl;
    coef_set_t  coef_used;

    assign ctrl.load  = accept;
    assign ctrl.start = s_tuser;
    assign ctrl.last  = s_tlast;

    sbq_coef_ramp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .target      (tgt_reg),
        .block_shift (shift_reg),
        .coef        (coef_used)
    );

    logic [NPORT-1:0][SAMPLE_BITS-1:0] s1_x_reg;
    logic [NPORT-1:0][SAMPLE_BITS-1:0] s1_mix_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int c = 0; c < NPORT; c++)
            begin
                s1_x_reg[c]   <= s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
                s1_mix_reg[c] <= s_tdata[(NPORT+c)*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // Stage 2: channel lanes
    logic [NPORT-1:0][SAMPLE_BITS-1:0] lane_res;

    for (genvar c = 0; c < NPORT; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            sbq_lane #(
                .SAMPLE_BITS    (SAMPLE_BITS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (adv),
                .coef  (coef_used),
                .x     ($signed(s1_x_reg[c])),
                .mix   ($signed(s1_mix_reg[c])),
                .res   (lane_res[c])
            );
        end
        else
        begin : g_off
            // no filter on this channel: pass the mix value
            assign lane_res[c] = s1_mix_reg[c];
        end
    end

    // Merge lanes into the output register
    logic [NPORT-1:0][SAMPLE_BITS-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= lane_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    `SBQ_ASSERT(a_no_overrun,
        s1_valid_reg && out_valid_reg && !m_tready |-> !s_tready,
        "request taken while both stages are stalled")
    `SBQ_ASSERT(a_ready_when_empty, !s1_valid_reg |-> s_tready,
        "input stalled with an empty first stage")
    `SBQ_ASSERT_NEXT(a_advance_fills_out, s1_valid_reg && out_free, out_valid_reg,
        "advanced request did not reach the output register")

endmodule

// ----- rtl/sbq_coef_ramp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sbq_coef_ramp
// Coefficient ramp: step computation at block start, per-request step add,
// snap to targets at block end. Registers the coefficient set used by the
// filter lanes for each request.
// ---------------------------------------------------------------------------
module sbq_coef_ramp #(
    parameter int COEF_FRAC_BITS = sbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbq_pkg::ramp_ctrl_t          ctrl,
    input  sbq_pkg::coef_set_t           target,
    input  logic [sbq_pkg::SHIFT_W-1:0]  block_shift,
    output sbq_pkg::coef_set_t           coef
);
    import sbq_pkg::*;

    localparam logic [COEF_W-1:0] UNITY = COEF_W'(64'd1 << COEF_FRAC_BITS);

    function automatic logic [COEF_W-1:0] sat_coef(input logic signed [COEF_W:0] v);
        if (v[COEF_W] != v[COEF_W-1])
        begin
            return v[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end
        return v[COEF_W-1:0];
    endfunction

    coef_set_t cur_reg, cur_next;
    coef_set_t step_reg, step_next;
    coef_set_t coef_reg;
    coef_set_t step_eff;
    coef_set_t used;

    logic signed [COEF_W:0] diff    [NCOEF];
    logic signed [COEF_W:0] diff_sh [NCOEF];
    logic signed [COEF_W:0] sum     [NCOEF];

    always_comb
    begin
        for (int i = 0; i < NCOEF; i++)
        begin
            diff[i]    = $signed({target[i][COEF_W-1], target[i]})
                       - $signed({cur_reg[i][COEF_W-1], cur_reg[i]});
            diff_sh[i] = diff[i] >>> block_shift;
            step_eff[i] = ctrl.start ? sat_coef(diff_sh[i]) : step_reg[i];
            sum[i]     = $signed({cur_reg[i][COEF_W-1], cur_reg[i]})
                       + $signed({step_eff[i][COEF_W-1], step_eff[i]});
            used[i]    = sat_coef(sum[i]);
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        step_next = step_reg;
        if (ctrl.load)
        begin
            if (ctrl.last)
            begin
                // snap to targets after this request
                cur_next  = target;
                step_next = '0;
            end
            else
            begin
                cur_next  = used;
                step_next = step_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            cur_reg[C_B0] <= UNITY;
            step_reg      <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            coef_reg <= used;
        end
    end

    assign coef = coef_reg;

    `SBQ_ASSERT_NEXT(a_snap_targets, ctrl.load && ctrl.last, cur_reg == $past(target) && step_reg == '0, "coefficients did not snap at block end")
    `SBQ_ASSERT_NEXT(a_step_hold, ctrl.load && !ctrl.start && !ctrl.last, step_reg == $past(step_reg), "step changed without block start")
    `SBQ_ASSERT_NEXT(a_idle_hold, !ctrl.load, cur_reg == $past(cur_reg), "coefficients moved without a request")

endmodule

// ----- rtl/sbq_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbq_lane
// One channel of the Direct Form I biquad: five products, rounding,
// saturation and the saturated add to the mix value.
// ---------------------------------------------------------------------------
module sbq_lane #(
    parameter int SAMPLE_BITS    = sbq_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = sbq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  sbq_pkg::coef_set_t            coef,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] mix,
    output logic signed [SAMPLE_BITS-1:0] res
);
    import sbq_pkg::*;

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = (PROD_W + 3 < 64) ? PROD_W + 3 : 64;

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc, acc_rnd, acc_sh;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS:0]   mix_sum;
    logic                          in_range;

    assign p_b0 = $signed(coef[C_B0]) * x;
    assign p_b1 = $signed(coef[C_B1]) * x1_reg;
    assign p_b2 = $signed(coef[C_B2]) * x2_reg;
    assign p_a1 = $signed(coef[C_A1]) * y1_reg;
    assign p_a2 = $signed(coef[C_A2]) * y2_reg;

    always_comb
    begin
        acc     = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
                - ACC_W'(p_a1) - ACC_W'(p_a2);
        acc_rnd = acc + HALF;
        acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
        in_range = (&acc_sh[ACC_W-1:SAMPLE_BITS-1]) || !(|acc_sh[ACC_W-1:SAMPLE_BITS-1]);
        if (in_range)
        begin
            y = acc_sh[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = acc_sh[ACC_W-1] ? SMIN : SMAX;
        end
        mix_sum = {mix[SAMPLE_BITS-1], mix} + {y[SAMPLE_BITS-1], y};
        if (mix_sum[SAMPLE_BITS] != mix_sum[SAMPLE_BITS-1])
        begin
            res = mix_sum[SAMPLE_BITS] ? SMIN : SMAX;
        end
        else
        begin
            res = mix_sum[SAMPLE_BITS-1:0];
        end
    end

    // advance the delay line once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (adv)
        begin
            x1_reg <= x;
            x2_reg <= x1_reg;
            y1_reg <= y;
            y2_reg <= y1_reg;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo ramped-coefficient biquad. A short
// table of hand-picked requests covers reset behavior, sample and mix
// saturation, block start/end combinations and extreme targets and shifts.
// It is followed by random phases, each with fresh targets, made mostly of
// well-formed ramp blocks. Every result is compared against an in-bench
// model of the filter, while the sender and receiver idle at random.
// ---------------------------------------------------------------------------
module tb_top;

    import sbq_pkg::*;

    localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
    localparam int FRAC_W         = DEF_COEF_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 830;
    localparam int PHASE_ITEMS    = 60;

    typedef struct packed {
        logic [SAMPLE_W-1:0] in_l;
        logic [SAMPLE_W-1:0] in_r;
        logic [SAMPLE_W-1:0] mix_l;
        logic [SAMPLE_W-1:0] mix_r;
        logic                blk_start;
        logic                blk_end;
    } audio_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } pair_t;

    typedef struct packed {
        logic [COEF_W-1:0]  b0;
        logic [COEF_W-1:0]  b1;
        logic [COEF_W-1:0]  b2;
        logic [COEF_W-1:0]  a1;
        logic [COEF_W-1:0]  a2;
        logic [SHIFT_W-1:0] shift;
    } coef_cfg_t;

    typedef struct {
        int cfg;      // directed setting to load first, -1 keeps the current one
        int in_l;
        int in_r;
        int mix_l;
        int mix_r;
        bit blk_start;
        bit blk_end;
        bit typed;    // expected result given below instead of predicted
        int exp_l;
        int exp_r;
    } dir_row_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [95:0]         s_tdata  = '0;  // in_left, in_right, mix_left, mix_right
    logic                s_tuser  = 1'b0; // block_start
    logic                s_tlast  = 1'b0; // block_end
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [47:0]         m_tdata;         // out_left, out_right

    // filter model state
    logic signed [COEF_W-1:0] tgt      [NCOEF];
    logic signed [COEF_W-1:0] coef_cur [NCOEF];
    logic signed [COEF_W-1:0] coef_stp [NCOEF];
    logic [SHIFT_W-1:0]       shift_cfg;
    longint                   x_hist [2][2];
    longint                   y_hist [2][2];

    pair_t     expected_out [$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    int        rx_left     = 0;
    int        rx_mode     = 0;
    int        rx_tick     = 0;
    dir_row_t  dir_rows [22];
    coef_cfg_t dir_cfgs [5];

    stereo_biquad_coef_ramp_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Advance the filter model by one request and return both channel outputs.
    function automatic void run_biquad(input audio_req_t req, output pair_t res);
        longint xs [2];
        longint mix [2];
        longint outs [2];
        longint acc;
        longint y;
        xs[0]  = longint'($signed(req.in_l));
        xs[1]  = longint'($signed(req.in_r));
        mix[0] = longint'($signed(req.mix_l));
        mix[1] = longint'($signed(req.mix_r));
        if (req.blk_start)
        begin
            for (int i = 0; i < NCOEF; i++)
                coef_stp[i] = COEF_W'(clamp((longint'(tgt[i]) - longint'(coef_cur[i]))
                                            >>> shift_cfg, COEF_W));
        end
        for (int i = 0; i < NCOEF; i++)
            coef_cur[i] = COEF_W'(clamp(longint'(coef_cur[i]) + longint'(coef_stp[i]),
                                        COEF_W));
        for (int c = 0; c < 2; c++)
        begin
            acc = longint'(coef_cur[C_B0]) * xs[c]
                + longint'(coef_cur[C_B1]) * x_hist[c][0]
                + longint'(coef_cur[C_B2]) * x_hist[c][1]
                - longint'(coef_cur[C_A1]) * y_hist[c][0]
                - longint'(coef_cur[C_A2]) * y_hist[c][1]
                + (longint'(1) <<< (FRAC_W - 1));
            y = clamp(acc >>> FRAC_W, SAMPLE_W);
            x_hist[c][1] = x_hist[c][0];
            x_hist[c][0] = xs[c];
            y_hist[c][1] = y_hist[c][0];
            y_hist[c][0] = y;
            outs[c] = clamp(mix[c] + y, SAMPLE_W);
        end
        if (req.blk_end)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_cur[i] = tgt[i];
                coef_stp[i] = '0;
            end
        end
        res.left  = SAMPLE_W'(outs[0]);
        res.right = SAMPLE_W'(outs[1]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        case (idx)
            REG_SHIFT: shift_cfg = val[SHIFT_W-1:0];
            default:   tgt[idx] = val;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_targets(input coef_cfg_t c);
        write_reg(REG_B0, c.b0);
        write_reg(REG_B1, c.b1);
        write_reg(REG_B2, c.b2);
        write_reg(REG_A1, c.a1);
        write_reg(REG_A2, c.a2);
        write_reg(REG_SHIFT, DATA_W'(c.shift));
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input audio_req_t req, input bit typed, input pair_t typed_out);
        pair_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {req.mix_r, req.mix_l, req.in_r, req.in_l};
        s_tuser  <= req.blk_start;
        s_tlast  <= req.blk_end;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        run_biquad(req, predicted);
        expected_out.push_back(typed ? typed_out : predicted);
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2, 3:    return SAMPLE_W'($urandom);
            4, 5, 6: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
            default: return SAMPLE_W'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input int kind, input int mag);
        case (kind)
            0, 1: return COEF_W'(int'($urandom_range(0, 2 * mag)) - mag);
            2:    return $urandom;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic coef_cfg_t rand_cfg();
        coef_cfg_t c;
        int kind;
        kind = $urandom_range(0, 3);
        c.b0 = rand_coef(kind, 2 ** 27);
        c.b1 = rand_coef(kind, 2 ** 27);
        c.b2 = rand_coef(kind, 2 ** 27);
        c.a1 = rand_coef(kind, 2 ** 28);
        c.a2 = rand_coef(kind, 2 ** 26);
        // favor short blocks so ramps complete often
        c.shift = SHIFT_W'(($urandom_range(0, 2) != 0) ? $urandom_range(0, 4)
                                                        : $urandom_range(0, 15));
        return c;
    endfunction

    // Receiver stall pattern: switch at random between four ready modes.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 120);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((rx_tick % 11) < 7);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(negedge clk)
    begin : result_check
        pair_t got;
        pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.left  = m_tdata[23:0];
            got.right = m_tdata[47:24];
            if (expected_out.size() == 0)
                report_mismatch($sformatf("result %0d/%0d with no request pending",
                                          $signed(got.left), $signed(got.right)));
            else
            begin
                want = expected_out.pop_front();
                if (got.left !== want.left)
                    report_mismatch($sformatf("out_left got %0d expected %0d",
                                              $signed(got.left), $signed(want.left)));
                if (got.right !== want.right)
                    report_mismatch($sformatf("out_right got %0d expected %0d",
                                              $signed(got.right), $signed(want.right)));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        audio_req_t req;
        pair_t      typed_out;
        int         blen;
        int         kind;
        int         phase_items;
        int         sent;

        dir_cfgs[0] = '{b0: 32'h0, b1: 32'h1000_0000, b2: 32'h0, a1: 32'h0, a2: 32'h0,
                        shift: 4'd0};
        dir_cfgs[1] = '{b0: 32'h8000_0000, b1: 32'h7FFF_FFFF, b2: 32'h8000_0000,
                        a1: 32'h7FFF_FFFF, a2: 32'h8000_0000, shift: 4'd15};
        dir_cfgs[2] = '{b0: 32'h7FFF_FFFF, b1: 32'h8000_0000, b2: 32'h7FFF_FFFF,
                        a1: 32'h8000_0000, a2: 32'h7FFF_FFFF, shift: 4'd0};
        dir_cfgs[3] = '{b0: 32'h0400_0000, b1: 32'h0800_0000, b2: 32'h0400_0000,
                        a1: 32'hF800_0000, a2: 32'h0200_0000, shift: 4'd2};
        dir_cfgs[4] = '{b0: 32'h0800_0000, b1: 32'hF000_0000, b2: 32'h0, a1: 32'h0,
                        a2: 32'h0, shift: 4'd12};

        dir_rows = '{
            // unity pass-through after reset: out = mix + in, saturated
            '{-1, 0, 0, 0, 0, 0, 0, 1, 0, 0},
            '{-1, 100, -100, 5, 7, 0, 0, 1, 105, -93},
            '{-1, 8388607, -8388608, 0, 0, 0, 0, 1, 8388607, -8388608},
            '{-1, 8388607, -8388608, 8388607, -8388608, 0, 0, 1, 8388607, -8388608},
            '{-1, -8388608, 8388607, 8388607, -8388608, 0, 0, 1, -1, -1},
            '{-1, 1, -1, 8388607, -8388608, 0, 0, 1, 8388607, -8388608},
            '{-1, 1000, 2000, 3, 4, 1, 1, 1, 1003, 2004},
            // one-sample delay, whole step at once, start without end keeps stepping
            '{0, 5, 6, 0, 0, 1, 0, 0, 0, 0},
            '{-1, 7, 8, 10, -10, 0, 0, 0, 0, 0},
            '{-1, -7, -8, 0, 0, 0, 1, 0, 0, 0},
            '{-1, 300, -300, 0, 0, 0, 0, 0, 0, 0},
            // extreme targets, shift beyond the nominal range
            '{1, 8388607, -8388608, 0, 0, 1, 0, 0, 0, 0},
            '{-1, -8388608, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0},
            '{-1, 4096, -4096, 0, 0, 0, 1, 0, 0, 0},
            // full-scale swing: steps saturate, start and end together
            '{2, 123, -456, 0, 0, 1, 1, 0, 0, 0},
            '{-1, -1, 1, 0, 0, 0, 0, 0, 0, 0},
            // well-formed block of four
            '{3, 40000, -40000, 0, 0, 1, 0, 0, 0, 0},
            '{-1, 80000, -80000, 100, -100, 0, 0, 0, 0, 0},
            '{-1, -20000, 20000, 0, 0, 0, 0, 0, 0, 0},
            '{-1, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            // largest nominal shift
            '{4, 1000000, -1000000, 0, 0, 1, 0, 0, 0, 0},
            '{-1, -1000000, 1000000, 0, 0, 0, 1, 0, 0, 0}
        };

        tgt[C_B0] = TGT_B0_RESET;
        for (int i = 1; i < NCOEF; i++)
            tgt[i] = '0;
        shift_cfg = SHIFT_RESET;
        for (int i = 0; i < NCOEF; i++)
        begin
            coef_cur[i] = '0;
            coef_stp[i] = '0;
        end
        coef_cur[C_B0] = TGT_B0_RESET;
        for (int c = 0; c < 2; c++)
            for (int k = 0; k < 2; k++)
            begin
                x_hist[c][k] = 0;
                y_hist[c][k] = 0;
            end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg >= 0)
            begin
                wait_idle();
                load_targets(dir_cfgs[dir_rows[i].cfg]);
            end
            req.in_l      = SAMPLE_W'(dir_rows[i].in_l);
            req.in_r      = SAMPLE_W'(dir_rows[i].in_r);
            req.mix_l     = SAMPLE_W'(dir_rows[i].mix_l);
            req.mix_r     = SAMPLE_W'(dir_rows[i].mix_r);
            req.blk_start = dir_rows[i].blk_start;
            req.blk_end   = dir_rows[i].blk_end;
            typed_out.left  = SAMPLE_W'(dir_rows[i].exp_l);
            typed_out.right = SAMPLE_W'(dir_rows[i].exp_r);
            send_item(req, dir_rows[i].typed, typed_out);
        end

        typed_out = '0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            load_targets(rand_cfg());
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                // mostly whole ramp blocks, the rest noise and broken blocks
                kind = $urandom_range(0, 9);
                blen = (kind < 7 && shift_cfg <= 5) ? (1 << shift_cfg) : $urandom_range(1, 24);
                for (int k = 0; k < blen; k++)
                begin
                    req.in_l  = rand_sample();
                    req.in_r  = rand_sample();
                    req.mix_l = ($urandom_range(0, 4) < 2) ? '0 : rand_sample();
                    req.mix_r = ($urandom_range(0, 4) < 2) ? '0 : rand_sample();
                    case (kind)
                        7:
                        begin
                            req.blk_start = ($urandom_range(0, 5) == 0);
                            req.blk_end   = ($urandom_range(0, 5) == 0);
                        end
                        8:
                        begin
                            req.blk_start = (k == 0);
                            req.blk_end   = 1'b0;
                        end
                        9:
                        begin
                            req.blk_start = 1'b0;
                            req.blk_end   = 1'b0;
                        end
                        default:
                        begin
                            req.blk_start = (k == 0);
                            req.blk_end   = (k == blen - 1);
                        end
                    endcase
                    pace();
                    send_item(req, 1'b0, typed_out);
                end
                phase_items += blen;
            end
            sent += phase_items;
        end

        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
